/* design/dnwp_pkg.sv */
// ----------------------------------------------------------------------------
// dnwp_pkg
// Shared types, constants and small calendar functions for the date
// normalizer: controller commands, datapath status and month tables.
// ----------------------------------------------------------------------------
package dnwp_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 10;
  localparam int unsigned NDAY_W  = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned SUM_W   = YEAR_W + 1;

  // Division by one hundred is a multiply by a scaled reciprocal.
  localparam int unsigned DIV100_W     = 13;
  localparam int unsigned PROD_W       = YEAR_W + DIV100_W;
  localparam int unsigned Q100_W       = 8;
  localparam logic [DIV100_W-1:0] DIV100_MUL = 13'd5243;

  // Division by seven of a day-of-year value, same scheme.
  localparam int unsigned PROD7_W      = 2 * DOY_W;
  localparam int unsigned Q7_W         = 7;
  localparam logic [PROD7_W-1:0] DIV7_MUL = 18'd293;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_YEAR,
    OP_SET_REM,
    OP_NORM,
    OP_DOY,
    OP_MUL_PREV,
    OP_SUM,
    OP_WDAY,
    OP_PARITY
  } dnwp_op_e;

  typedef struct packed {
    dnwp_op_e op;
    logic     out_load;
  } dnwp_cmd_t;

  typedef struct packed {
    logic norm_done;
  } dnwp_status_t;

  function automatic logic [NDAY_W-1:0] dnwp_month_days(
    input logic [MONTH_W-1:0] month,
    input logic               leap
  );
    logic [NDAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before the given one, for a common year.
  function automatic logic [DOY_W-1:0] dnwp_days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] cum;
    case (month)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

  // Remainder modulo seven, folding octal digits since eight is one modulo seven.
  function automatic logic [WDAY_W-1:0] dnwp_mod7(input logic [SUM_W-1:0] s);
    logic [5:0] a;
    logic [3:0] b;
    a = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]} + {3'd0, s[11:9]}
      + {3'd0, s[14:12]};
    b = {1'b0, a[5:3]} + {1'b0, a[2:0]};
    if (b >= 4'd7) begin
      b = b - 4'd7;
    end
    return b[2:0];
  endfunction

endpackage

/* design/date_normalize_week_parity_core.sv */
// ----------------------------------------------------------------------------
// date_normalize_week_parity_core
// Normalizes a Gregorian date with an overflowing day and reports the leap
// flag, the weekday of January 1 and the week parity of the result.
// ----------------------------------------------------------------------------
// One request is processed at a time. Normalization steps through the
// month-stepping loop in the datapath once for each month the day overflows.
// A new request is taken as soon as the previous one is finished, even while
// its result still waits in the output register.
module date_normalize_week_parity_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dnwp_pkg::YEAR_W-1:0]   start_year_i,
  input  logic [dnwp_pkg::MONTH_W-1:0]  start_month_i,
  input  logic [dnwp_pkg::DAY_W-1:0]    start_day_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dnwp_pkg::YEAR_W-1:0]   norm_year_o,
  output logic [dnwp_pkg::MONTH_W-1:0]  norm_month_o,
  output logic [dnwp_pkg::NDAY_W-1:0]   norm_day_o,
  output logic                          leap_flag_o,
  output logic [dnwp_pkg::WDAY_W-1:0]   jan_first_weekday_o,
  output logic                          week_parity_o
);
  import dnwp_pkg::*;

  dnwp_cmd_t    cmd;
  dnwp_status_t status;

  dnwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dnwp_datapath u_datapath (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .start_year_i        (start_year_i),
    .start_month_i       (start_month_i),
    .start_day_i         (start_day_i),
    .norm_year_o         (norm_year_o),
    .norm_month_o        (norm_month_o),
    .norm_day_o          (norm_day_o),
    .leap_flag_o         (leap_flag_o),
    .jan_first_weekday_o (jan_first_weekday_o),
    .week_parity_o       (week_parity_o)
  );

endmodule

/* design/dnwp_datapath.sv */
// ----------------------------------------------------------------------------
// dnwp_datapath
// Date registers, month stepping, the shared divide-by-hundred multiplier,
// weekday and week parity arithmetic, and the result register.
// ----------------------------------------------------------------------------
module dnwp_datapath (
  input  logic                          clk_i,
  input  dnwp_pkg::dnwp_cmd_t           cmd_i,
  output dnwp_pkg::dnwp_status_t        status_o,
  input  logic [dnwp_pkg::YEAR_W-1:0]   start_year_i,
  input  logic [dnwp_pkg::MONTH_W-1:0]  start_month_i,
  input  logic [dnwp_pkg::DAY_W-1:0]    start_day_i,
  output logic [dnwp_pkg::YEAR_W-1:0]   norm_year_o,
  output logic [dnwp_pkg::MONTH_W-1:0]  norm_month_o,
  output logic [dnwp_pkg::NDAY_W-1:0]   norm_day_o,
  output logic                          leap_flag_o,
  output logic [dnwp_pkg::WDAY_W-1:0]   jan_first_weekday_o,
  output logic                          week_parity_o
);
  import dnwp_pkg::*;

  logic [YEAR_W-1:0]  year_q, year_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic [DAY_W-1:0]   day_q, day_d;
  logic [6:0]         r100_q, r100_d;
  logic [1:0]         q4_q, q4_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [DOY_W-1:0]   doy_q, doy_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [WDAY_W-1:0]  wday_q, wday_d;
  logic               par_q, par_d;

  logic                leap;
  logic [NDAY_W-1:0]   dim;
  logic                step;
  logic [YEAR_W-1:0]   year_inc;
  logic [YEAR_W-1:0]   prev_year;
  logic [Q100_W-1:0]   quot100;
  logic [YEAR_W-1:0]   rem_full;
  logic [WDAY_W-1:0]   k0;
  logic [DOY_W-1:0]    sat_off;
  logic [PROD7_W-1:0]  prod7;
  logic [Q7_W-1:0]     quot7;

  assign leap = ((year_q[1:0] == 2'd0) && (r100_q != 7'd0))
             || ((r100_q == 7'd0) && (q4_q == 2'd0));
  assign dim       = dnwp_month_days(month_q, leap);
  assign step      = day_q > {{(DAY_W-NDAY_W){1'b0}}, dim};
  assign year_inc  = year_q + YEAR_W'(1);
  assign prev_year = (year_q == '0) ? '0 : year_q - YEAR_W'(1);
  assign quot100   = prod_q[PROD_W-1 -: Q100_W];
  assign rem_full  = year_q - {{(YEAR_W-Q100_W){1'b0}}, quot100} * YEAR_W'(100);
  assign k0        = 3'd6 - wday_q;
  assign sat_off   = doy_q - DOY_W'(1) - {{(DOY_W-WDAY_W){1'b0}}, k0};
  assign prod7     = {{(PROD7_W-DOY_W){1'b0}}, sat_off} * DIV7_MUL;
  assign quot7     = prod7[PROD7_W-1 -: Q7_W];

  assign status_o.norm_done = !step;

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    r100_d  = r100_q;
    q4_d    = q4_q;
    prod_d  = prod_q;
    doy_d   = doy_q;
    sum_d   = sum_q;
    wday_d  = wday_q;
    par_d   = par_q;
    case (cmd_i.op)
      OP_LOAD: begin
        day_d = start_day_i;
        if (start_month_i == '0) begin
          year_d  = start_year_i;
          month_d = MONTH_JAN;
        end else if (start_month_i > MONTH_DEC) begin
          year_d  = start_year_i + YEAR_W'(1);
          month_d = MONTH_JAN;
        end else begin
          year_d  = start_year_i;
          month_d = start_month_i;
        end
      end
      OP_MUL_YEAR: begin
        prod_d = {{DIV100_W{1'b0}}, year_q} * {{YEAR_W{1'b0}}, DIV100_MUL};
      end
      OP_SET_REM: begin
        r100_d = rem_full[6:0];
        q4_d   = quot100[1:0];
      end
      OP_NORM: begin
        if (step) begin
          day_d = day_q - {{(DAY_W-NDAY_W){1'b0}}, dim};
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_inc;
            if (year_inc == '0) begin
              r100_d = 7'd0;
              q4_d   = 2'd0;
            end else if (r100_q == 7'd99) begin
              r100_d = 7'd0;
              q4_d   = q4_q + 2'd1;
            end else begin
              r100_d = r100_q + 7'd1;
            end
          end else begin
            month_d = month_q + MONTH_W'(1);
          end
        end
      end
      OP_DOY: begin
        doy_d = dnwp_days_before(month_q)
              + {{(DOY_W-1){1'b0}}, (leap && (month_q > MONTH_FEB))}
              + day_q[DOY_W-1:0] - DOY_W'(1);
      end
      OP_MUL_PREV: begin
        prod_d = {{DIV100_W{1'b0}}, prev_year} * {{YEAR_W{1'b0}}, DIV100_MUL};
      end
      OP_SUM: begin
        sum_d = {1'b0, year_q}
              + {3'd0, prev_year[YEAR_W-1:2]}
              - {{(SUM_W-Q100_W){1'b0}}, quot100}
              + {{(SUM_W-Q100_W+2){1'b0}}, quot100[Q100_W-1:2]};
      end
      OP_WDAY: begin
        wday_d = dnwp_mod7(sum_q);
      end
      OP_PARITY: begin
        if (day_q == '0) begin
          par_d = 1'b0;
        end else if (doy_q > {{(DOY_W-WDAY_W){1'b0}}, k0}) begin
          par_d = ~quot7[0];
        end else begin
          par_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    r100_q  <= r100_d;
    q4_q    <= q4_d;
    prod_q  <= prod_d;
    doy_q   <= doy_d;
    sum_q   <= sum_d;
    wday_q  <= wday_d;
    par_q   <= par_d;
    if (cmd_i.out_load) begin
      norm_year_o         <= year_q;
      norm_month_o        <= month_q;
      norm_day_o          <= day_q[NDAY_W-1:0];
      leap_flag_o         <= leap;
      jan_first_weekday_o <= wday_q;
      week_parity_o       <= par_q;
    end
  end

endmodule

/* design/dnwp_ctrl.sv */
// ----------------------------------------------------------------------------
// dnwp_ctrl
// Sequencer for the date normalizer: takes a request, steps the datapath
// through normalization and the calendar arithmetic, and holds the result
// valid until it is taken.
// ----------------------------------------------------------------------------
module dnwp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dnwp_pkg::dnwp_cmd_t    cmd_o,
  input  dnwp_pkg::dnwp_status_t status_i
);
  import dnwp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_Y,
    S_REM_Y,
    S_NORM,
    S_DOY,
    S_MUL_P,
    S_SUM,
    S_WDAY,
    S_PAR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        cmd_o.op = OP_MUL_YEAR;
        state_d  = S_REM_Y;
      end
      S_REM_Y: begin
        cmd_o.op = OP_SET_REM;
        state_d  = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        if (status_i.norm_done) begin
          state_d = S_DOY;
        end
      end
      S_DOY: begin
        cmd_o.op = OP_DOY;
        state_d  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL_PREV;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_WDAY;
      end
      S_WDAY: begin
        cmd_o.op = OP_WDAY;
        state_d  = S_PAR;
      end
      S_PAR: begin
        cmd_o.op = OP_PARITY;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result became valid without a finished request.");

  a_norm_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NORM && !status_i.norm_done) |=> (state_q == S_NORM))
    else $error("Normalization left before the day fit its month.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_MUL_Y))
    else $error("Accepted request did not start processing.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("Pending result overwritten.");

endmodule

/* bench/tb_date_normalize_week_parity_core.sv */
// ----------------------------------------------------------------------------
// tb_date_normalize_week_parity_core
// Drives date requests into the normalizer under random gaps and output
// stalls, predicts every result in the bench and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_date_normalize_week_parity_core;
  import dnwp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_IDLE = 18;
  localparam int unsigned YEAR_MAX = (1 << YEAR_W) - 1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [NDAY_W-1:0]  day;
    logic               leap;
    logic [WDAY_W-1:0]  weekday;
    logic               parity;
  } date_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [YEAR_W-1:0]  start_year_i;
  logic [MONTH_W-1:0] start_month_i;
  logic [DAY_W-1:0]   start_day_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [YEAR_W-1:0]  norm_year_o;
  logic [MONTH_W-1:0] norm_month_o;
  logic [NDAY_W-1:0]  norm_day_o;
  logic               leap_flag_o;
  logic [WDAY_W-1:0]  jan_first_weekday_o;
  logic               week_parity_o;

  date_result_t expected_dates[$];
  int unsigned  requests_sent;
  int unsigned  results_checked;
  int unsigned  failures;
  int unsigned  cycle_count;
  int unsigned  hold_cycles;
  bit           tx_no_gaps;
  bit           rx_no_stall;

  date_normalize_week_parity_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .start_year_i        (start_year_i),
    .start_month_i       (start_month_i),
    .start_day_i         (start_day_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .norm_year_o         (norm_year_o),
    .norm_month_o        (norm_month_o),
    .norm_day_o          (norm_day_o),
    .leap_flag_o         (leap_flag_o),
    .jan_first_weekday_o (jan_first_weekday_o),
    .week_parity_o       (week_parity_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned is_leap_year(input int unsigned year);
    return ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0) ? 1 : 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned month,
                                               input int unsigned leap);
    int unsigned len;
    case (month)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      MONTH_FEB:             len = (leap != 0) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic date_result_t predict_date(input logic [YEAR_W-1:0] year_in,
                                                input logic [MONTH_W-1:0] month_in,
                                                input logic [DAY_W-1:0] day_in);
    int unsigned year, month, day, leap, prior, weekday, doy, first_sat, sats;
    date_result_t res;
    year = year_in;
    month = month_in;
    day = day_in;
    if (month == 0) begin
      month = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      month = MONTH_JAN;
      year = (year + 1) & YEAR_MAX;
    end
    leap = is_leap_year(year);
    while (day > month_length(month, leap)) begin
      day -= month_length(month, leap);
      month++;
      if (month > MONTH_DEC) begin
        month = MONTH_JAN;
        year = (year + 1) & YEAR_MAX;
        leap = is_leap_year(year);
      end
    end
    prior = (year == 0) ? 0 : year - 1;
    weekday = (year + prior / 4 - prior / 100 + prior / 400) % 7;
    sats = 0;
    if (day != 0) begin
      doy = day - 1;
      for (int unsigned m = MONTH_JAN; m < month; m++) begin
        doy += month_length(m, leap);
      end
      first_sat = (13 - weekday) % 7;
      sats = (doy > first_sat) ? (doy - 1 - first_sat) / 7 + 1 : 0;
    end
    res.year = year[YEAR_W-1:0];
    res.month = month[MONTH_W-1:0];
    res.day = day[NDAY_W-1:0];
    res.leap = leap[0];
    res.weekday = weekday[WDAY_W-1:0];
    res.parity = sats[0];
    return res;
  endfunction

  task automatic send_date(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month,
                           input logic [DAY_W-1:0] day);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_year_i <= year;
    start_month_i <= month;
    start_day_i <= day;
    do @(posedge clk_i); while (in_stall_o);
    expected_dates.push_back(predict_date(year, month, day));
    requests_sent++;
  endtask

  // Receiver: draws a stall length per result, or uses any requested long hold-off in its place.
  initial begin
    int unsigned wait_cycles;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      wait_cycles = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_cycles != 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    date_result_t want;
    date_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{norm_year_o, norm_month_o, norm_day_o, leap_flag_o,
              jan_first_weekday_o, week_parity_o};
      if (expected_dates.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] result with no request pending: year %0d month %0d day %0d",
                   $time, got.year, got.month, got.day);
        end
      end else begin
        want = expected_dates.pop_front();
        results_checked++;
        if (got.year != want.year || got.month != want.month || got.day != want.day
            || got.leap != want.leap || got.weekday != want.weekday
            || got.parity != want.parity) begin
          failures++;
          if (failures <= 10) begin
            $display("[%0t] mismatch: expected %0d-%0d-%0d leap %0d wday %0d parity %0d,",
                     $time, want.year, want.month, want.day, want.leap, want.weekday,
                     want.parity);
            $display("             got      %0d-%0d-%0d leap %0d wday %0d parity %0d",
                     got.year, got.month, got.day, got.leap, got.weekday, got.parity);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_dates.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_date(14'd1, 4'd1, 10'd1);
    send_date(14'd9990, 4'd12, 10'd31);
    send_date(14'd0, 4'd1, 10'd1);
    send_date(14'd0, MONTH_FEB, 10'd29);
    send_date(14'd16383, 4'd12, 10'd1023);
    send_date(14'd16383, 4'd13, 10'd1);
    send_date(14'd16383, 4'd15, 10'd1023);
    send_date(14'd5, 4'd0, 10'd40);
    send_date(14'd2024, 4'd15, 10'd0);
    send_date(14'd1, 4'd1, 10'd0);
    send_date(14'd9990, 4'd1, 10'd1023);
    send_date(14'd10922, 4'd5, 10'd341);
    send_date(14'd5461, 4'd10, 10'd682);
  endtask

  task automatic test_leap_rules();
    send_date(14'd2000, MONTH_FEB, 10'd29);
    send_date(14'd1900, MONTH_FEB, 10'd29);
    send_date(14'd2024, MONTH_FEB, 10'd29);
    send_date(14'd2023, MONTH_FEB, 10'd29);
    send_date(14'd2100, MONTH_FEB, 10'd29);
    send_date(14'd1900, 4'd1, 10'd366);
    send_date(14'd2000, 4'd1, 10'd366);
    send_date(14'd1999, 4'd12, 10'd32);
    send_date(14'd2023, 4'd11, 10'd95);
    // January 7, 2023 is a Saturday, so the week index flips on the 8th.
    send_date(14'd2023, 4'd1, 10'd7);
    send_date(14'd2023, 4'd1, 10'd8);
  endtask

  task automatic test_output_hold_off();
    tx_no_gaps = 1'b1;
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) begin
      send_date(YEAR_W'($urandom_range(1, 9990)), MONTH_W'($urandom_range(1, 12)),
                DAY_W'($urandom_range(1, 200)));
    end
    tx_no_gaps = 1'b0;
  endtask

  task automatic test_random_dates(input int unsigned count);
    int unsigned kind;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        tx_no_gaps = ($urandom_range(0, 3) == 0);
        rx_no_stall = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        year = YEAR_W'($urandom_range(0, YEAR_MAX));
        month = MONTH_W'($urandom_range(0, 15));
        day = DAY_W'($urandom_range(0, 1023));
      end else begin
        year = YEAR_W'($urandom_range(1, 9990));
        month = MONTH_W'($urandom_range(1, 12));
        if (kind < 5) begin
          day = DAY_W'($urandom_range(1, 31));
        end else if (kind < 8) begin
          day = DAY_W'($urandom_range(1, 400));
        end else begin
          day = DAY_W'($urandom_range(1, 1023));
        end
      end
      send_date(year, month, day);
    end
    tx_no_gaps = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_year_i = '0;
    start_month_i = '0;
    start_day_i = '0;
    requests_sent = 0;
    results_checked = 0;
    failures = 0;
    cycle_count = 0;
    hold_cycles = 0;
    tx_no_gaps = 1'b0;
    rx_no_stall = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_leap_rules();
    test_output_hold_off();
    test_random_dates(1150);

    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Normalized %0d dates, %0d results compared, %0d failures.",
             requests_sent, results_checked, failures);
    $display("Covered leap and century rules, year wrap, month and day corner values.");
    if (failures == 0 && expected_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/dnwp_pkg.sv
design/dnwp_datapath.sv
design/dnwp_ctrl.sv
design/date_normalize_week_parity_core.sv
bench/tb_date_normalize_week_parity_core.sv
